>>> src/tpd_pkg.sv
// Package for the tagged primitive decoder: parse phases, tag codes and the
// result record passed from the parser to the top level. No dependencies.
`default_nettype none

package tpd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_EXTTAG,
    PH_EXTLEN,
    PH_LENBYTES,
    PH_CONTENT,
    PH_SKIP
  } tpd_phase_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_OK,
    RES_ERR
  } tpd_res_e;

  // Application tag numbers
  localparam logic [7:0] TAG_NULL     = 8'd0;
  localparam logic [7:0] TAG_BOOLEAN  = 8'd1;
  localparam logic [7:0] TAG_UNSIGNED = 8'd2;
  localparam logic [7:0] TAG_SIGNED   = 8'd3;
  localparam logic [7:0] TAG_REAL     = 8'd4;
  localparam logic [7:0] TAG_DOUBLE   = 8'd5;
  localparam logic [7:0] TAG_OCTETSTR = 8'd6;
  localparam logic [7:0] TAG_CHARSTR  = 8'd7;
  localparam logic [7:0] TAG_BITSTR   = 8'd8;
  localparam logic [7:0] TAG_ENUM     = 8'd9;
  localparam logic [7:0] TAG_DATE     = 8'd10;
  localparam logic [7:0] TAG_TIME     = 8'd11;
  localparam logic [7:0] TAG_OBJID    = 8'd12;

  localparam logic [3:0] TAG_EXTENDED = 4'd15;
  localparam logic [7:0] TAG_RESERVED = 8'd255;
  localparam logic [2:0] LVT_EXTENDED = 3'd5;
  localparam logic [7:0] LEN_16BIT    = 8'd254;
  localparam logic [15:0] YEAR_BASE   = 16'd1900;
  localparam logic [15:0] YEAR_ANY    = 16'hFFFF;

  typedef struct packed {
    logic        error;
    logic [3:0]  tag_number;
    logic [63:0] value;
    logic [34:0] content_length;
    logic [7:0]  aux_octet;
    logic [3:0]  content_offset;
    logic [32:0] consumed;
  } tpd_result_t;

endpackage

`default_nettype wire

>>> src/tpd_parser.sv
// Octet-at-a-time parser state and result formatting for one tagged primitive.
// Depends on tpd_pkg.
`default_nettype none

module tpd_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          octet_i,
  input  wire logic                final_octet_i,
  output logic                     res_valid_o,
  output tpd_pkg::tpd_result_t     result_o
);
  import tpd_pkg::*;

  tpd_phase_e  phase_q, phase_d;
  logic [7:0]  tag_q, tag_d;
  logic [2:0]  lvt_q, lvt_d;
  logic [31:0] len_q, len_d;
  logic [2:0]  hc_q, hc_d;
  logic [31:0] cc_q, cc_d;
  logic [63:0] acc_q, acc_d;
  logic [7:0]  first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      tag_q   <= '0;
      lvt_q   <= '0;
      len_q   <= '0;
      hc_q    <= '0;
      cc_q    <= '0;
      acc_q   <= '0;
      first_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tag_q   <= tag_d;
      lvt_q   <= lvt_d;
      len_q   <= len_d;
      hc_q    <= hc_d;
      cc_q    <= cc_d;
      acc_q   <= acc_d;
      first_q <= first_d;
    end
  end

  tpd_res_e    res;
  logic        tk_en;
  logic [7:0]  tk_tag;
  logic        lk_en;
  logic        len_bad;
  logic [31:0] len_m1;
  logic [15:0] year;
  logic [63:0] val;
  logic [34:0] clen;
  logic [7:0]  aux;
  logic [3:0]  off;

  always_comb begin
    phase_d = phase_q;
    tag_d   = tag_q;
    lvt_d   = lvt_q;
    len_d   = len_q;
    hc_d    = hc_q;
    cc_d    = cc_q;
    acc_d   = acc_q;
    first_d = first_q;
    res     = RES_NONE;
    tk_en   = 1'b0;
    tk_tag  = '0;
    lk_en   = 1'b0;
    len_bad = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        tag_d   = '0;
        len_d   = '0;
        cc_d    = '0;
        acc_d   = '0;
        first_d = '0;
        hc_d    = 3'd1;
        lvt_d   = octet_i[2:0];
        // context class, opening and closing tags
        if (octet_i[3] || octet_i[2:1] == 2'b11) begin
          res = RES_ERR;
        end else if (octet_i[7:4] == TAG_EXTENDED) begin
          phase_d = PH_EXTTAG;
        end else begin
          tk_en  = 1'b1;
          tk_tag = {4'd0, octet_i[7:4]};
        end
      end
      PH_EXTTAG: begin
        hc_d = 3'd2;
        if (octet_i == TAG_RESERVED) begin
          res = RES_ERR;
        end else begin
          tk_en  = 1'b1;
          tk_tag = octet_i;
        end
      end
      PH_EXTLEN: begin
        hc_d = hc_q + 3'd1;
        if (octet_i < LEN_16BIT) begin
          len_d = {24'd0, octet_i};
          lk_en = 1'b1;
        end else begin
          cc_d    = (octet_i == LEN_16BIT) ? 32'd2 : 32'd4;
          len_d   = '0;
          phase_d = PH_LENBYTES;
        end
      end
      PH_LENBYTES: begin
        hc_d  = hc_q + 3'd1;
        len_d = {len_q[23:0], octet_i};
        cc_d  = cc_q - 32'd1;
        if (cc_d == 32'd0) lk_en = 1'b1;
      end
      PH_CONTENT: begin
        if (cc_q == 32'd0) begin
          first_d = octet_i;
          if (tag_q == TAG_BITSTR &&
              (octet_i > 8'd7 || (len_q == 32'd1 && octet_i != 8'd0))) begin
            res = RES_ERR;
          end
        end
        if (res == RES_NONE) begin
          acc_d = {acc_q[55:0], octet_i};
          cc_d  = cc_q + 32'd1;
          if (cc_d == len_q) res = RES_OK;
        end
      end
      default: begin
      end
    endcase

    if (tk_en) begin
      tag_d = tk_tag;
      if (tk_tag == TAG_NULL) begin
        res = (lvt_d == 3'd0) ? RES_OK : RES_ERR;
      end else if (tk_tag == TAG_BOOLEAN) begin
        res = (lvt_d <= 3'd1) ? RES_OK : RES_ERR;
      end else if (tk_tag > TAG_OBJID) begin
        res = RES_ERR;
      end else if (lvt_d < LVT_EXTENDED) begin
        len_d = {29'd0, lvt_d};
        lk_en = 1'b1;
      end else begin
        phase_d = PH_EXTLEN;
      end
    end

    if (lk_en) begin
      case (tag_d)
        TAG_UNSIGNED, TAG_SIGNED, TAG_ENUM: len_bad = (len_d < 32'd1 || len_d > 32'd4);
        TAG_REAL, TAG_DATE, TAG_TIME, TAG_OBJID: len_bad = (len_d != 32'd4);
        TAG_DOUBLE: len_bad = (len_d != 32'd8);
        TAG_CHARSTR, TAG_BITSTR: len_bad = (len_d == 32'd0);
        TAG_OCTETSTR: len_bad = 1'b0;
        default: len_bad = 1'b1;
      endcase
      if (len_bad) begin
        res = RES_ERR;
      end else if (len_d == 32'd0) begin
        res = RES_OK;
      end else begin
        cc_d    = '0;
        acc_d   = '0;
        phase_d = PH_CONTENT;
      end
    end

    // buffer ended before the value was complete
    if (res == RES_NONE && final_octet_i && phase_q != PH_SKIP) res = RES_ERR;

    if (res == RES_NONE) begin
      if (final_octet_i) phase_d = PH_HEADER;
    end else begin
      phase_d = final_octet_i ? PH_HEADER : PH_SKIP;
    end
  end

  // Result fields, built from the updated state
  always_comb begin
    val    = '0;
    clen   = '0;
    aux    = '0;
    off    = {1'b0, hc_d};
    len_m1 = len_d - 32'd1;
    year   = (acc_d[31:24] == 8'hFF) ? YEAR_ANY : YEAR_BASE + {8'd0, acc_d[31:24]};
    case (tag_d)
      TAG_BOOLEAN: val = {61'd0, lvt_d};
      TAG_UNSIGNED, TAG_REAL, TAG_DOUBLE, TAG_ENUM, TAG_TIME: val = acc_d;
      TAG_SIGNED: begin
        case (len_d[2:0])
          3'd1: val = {{56{acc_d[7]}}, acc_d[7:0]};
          3'd2: val = {{48{acc_d[15]}}, acc_d[15:0]};
          3'd3: val = {{40{acc_d[23]}}, acc_d[23:0]};
          default: val = {{32{acc_d[31]}}, acc_d[31:0]};
        endcase
      end
      TAG_OCTETSTR: clen = {3'd0, len_d};
      TAG_CHARSTR: begin
        clen = {3'd0, len_m1};
        aux  = first_d;
        off  = {1'b0, hc_d} + 4'd1;
      end
      TAG_BITSTR: begin
        clen = {len_m1, 3'b000} - {27'd0, first_d};
        aux  = first_d;
        off  = {1'b0, hc_d} + 4'd1;
      end
      TAG_DATE: val = {24'd0, year, acc_d[23:0]};
      TAG_OBJID: val = {22'd0, acc_d[31:22], 10'd0, acc_d[21:0]};
      default: begin
      end
    endcase
  end

  always_comb begin
    res_valid_o = (res != RES_NONE);
    result_o    = '0;
    if (res == RES_ERR) begin
      result_o.error = 1'b1;
    end else begin
      result_o.tag_number     = tag_d[3:0];
      result_o.value          = val;
      result_o.content_length = clen;
      result_o.aux_octet      = aux;
      result_o.content_offset = off;
      result_o.consumed       = {30'd0, hc_d} + {1'b0, len_d};
    end
  end

  a_fin_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && final_octet_i |=> phase_q == PH_HEADER)
    else $error("final octet did not return parser to header phase");

  a_result_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_valid_o && !final_octet_i |=> phase_q == PH_SKIP)
    else $error("result without final octet did not enter skip phase");

  a_content_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CONTENT |-> cc_q < len_q)
    else $error("content count reached length without a result");

  a_lenbytes_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_LENBYTES |-> (cc_q != 32'd0 && cc_q <= 32'd4))
    else $error("extended length octet count out of range");

endmodule

`default_nettype wire

>>> src/tagged_primitive_decoder.sv
// Top level of the tagged primitive decoder: input register, parser, result register.
// Depends on tpd_pkg and tpd_parser.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_stall_o  octet_i, final_octet_i
//   out      output     out_valid_o / out_stall_i error_o .. consumed_o
//
// One octet per cycle unless a result waits on a stalled output; the octet that
// completes the value or shows the error passes the input register, then the result register.
// The parser advances whenever its held octet can move on; an octet with a
// result waits only while the result register is full and stalled.
// Reset puts the parser at the header phase with empty registers.
`default_nettype none

module tagged_primitive_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  octet_i,
  input  wire logic        final_octet_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             error_o,
  output logic [3:0]       tag_number_o,
  output logic [63:0]      value_o,
  output logic [34:0]      content_length_o,
  output logic [7:0]       aux_octet_o,
  output logic [3:0]       content_offset_o,
  output logic [32:0]      consumed_o
);
  import tpd_pkg::*;

  logic        s1_valid_q;
  logic [7:0]  s1_octet_q;
  logic        s1_fin_q;
  logic        s1_adv;
  logic        out_free;
  logic        res_valid;
  tpd_result_t result;
  logic        out_valid_q;
  tpd_result_t out_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  // an octet without a result never needs the output register
  assign s1_adv     = s1_valid_q && (out_free || !res_valid);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_octet_q <= octet_i;
      s1_fin_q   <= final_octet_i;
    end
  end

  tpd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .octet_i       (s1_octet_q),
    .final_octet_i (s1_fin_q),
    .res_valid_o   (res_valid),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && res_valid) out_q <= result;
  end

  assign out_valid_o      = out_valid_q;
  assign error_o          = out_q.error;
  assign tag_number_o     = out_q.tag_number;
  assign value_o          = out_q.value;
  assign content_length_o = out_q.content_length;
  assign aux_octet_o      = out_q.aux_octet;
  assign content_offset_o = out_q.content_offset;
  assign consumed_o       = out_q.consumed;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && res_valid |-> out_free)
    else $error("result register overwritten while stalled");

  a_held_octet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_octet_q) && $stable(s1_fin_q))
    else $error("held octet lost before the parser took it");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.error |-> out_q.tag_number == 4'd0 && out_q.consumed == 33'd0)
    else $error("error result carries nonzero fields");

endmodule

`default_nettype wire
